>>> hw/rtl/rgtc_pkg.sv
// Shared types and constants for the RGTC block decoder.
package rgtc_pkg;

   localparam int unsigned BLOCK_W    = 64;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned CODE_W     = 3;
   localparam int unsigned NUM_TEXELS = 16;
   localparam int unsigned NUM_LANES  = 1 << CODE_W;
   localparam int unsigned CODES_W    = CODE_W * NUM_TEXELS;
   localparam int unsigned INDEX_W    = $clog2(NUM_TEXELS);
   localparam int unsigned ENDP_W     = 10;
   localparam int unsigned UVAL_W     = 8;
   localparam int unsigned SVAL_W     = 16;

   localparam logic [BYTE_W-1:0] BYTE_NEG_MAX   = 8'h80;
   localparam logic [BYTE_W-1:0] BYTE_NEG_CLAMP = 8'h81;
   localparam logic [INDEX_W-1:0] LAST_TEXEL    = INDEX_W'(NUM_TEXELS - 1);

   typedef struct packed {
      logic signed [ENDP_W-1:0] e0;
      logic signed [ENDP_W-1:0] e1;
      logic                     eight;
      logic                     sgn;
   } ends_type;

   typedef struct packed {
      logic [UVAL_W-1:0]        uval;
      logic signed [SVAL_W-1:0] sval;
   } lane_out_type;

endpackage

>>> hw/rtl/rgtc_block_decoder.sv
// Top level of the RGTC (BC4/BC5) block decoder.
// Path: an item passes the input stage, the palette lane registers and the result register.
// Throughput: one texel per cycle while rsp_stall is low, set by the single result port.
// The next item is held in the input stage while the serializer emits the current one.
// Reset clears signed_mode, the pair-failure flag and all valid state.
module rgtc_block_decoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic                                csr_write_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [rgtc_pkg::BLOCK_W-1:0]        req_block_bits,
   input  logic                                req_channel,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rgtc_pkg::INDEX_W-1:0]        rsp_texel_index,
   output logic [rgtc_pkg::UVAL_W-1:0]         rsp_unsigned_value,
   output logic signed [rgtc_pkg::SVAL_W-1:0]  rsp_signed_value,
   output logic                                rsp_component,
   output logic                                rsp_invalid,
   output logic                                rsp_last
);
   import rgtc_pkg::*;

   logic                  signed_mode_ff;
   logic                  pair_failed_ff;
   logic                  pair_failed_in;
   logic                  front_valid_ff;
   ends_type              front_ends_ff;
   ends_type              ends_in;
   logic [CODES_W-1:0]    front_codes_ff;
   logic                  front_bad_ff;
   logic                  front_bad_in;
   logic                  front_comp_ff;
   logic                  back_free;
   logic                  front_take;
   logic                  req_accept;
   logic                  bad_raw;
   logic [BYTE_W-1:0]     b0;
   logic [BYTE_W-1:0]     b1;
   lane_out_type [NUM_LANES-1:0] palette;

   assign req_stall  = front_valid_ff && !back_free;
   assign req_accept = req_valid && !req_stall;
   assign front_take = front_valid_ff && back_free;

   always_comb begin
      b0 = req_block_bits[BYTE_W-1:0];
      b1 = req_block_bits[2*BYTE_W-1:BYTE_W];
      bad_raw = signed_mode_ff && b0 == BYTE_NEG_CLAMP && b1 == BYTE_NEG_MAX;
      ends_in.sgn = signed_mode_ff;
      if (signed_mode_ff) begin
         ends_in.e0 = (b0 == BYTE_NEG_MAX) ? ENDP_W'($signed(BYTE_NEG_CLAMP))
                                            : ENDP_W'($signed(b0));
         ends_in.e1 = (b1 == BYTE_NEG_MAX) ? ENDP_W'($signed(BYTE_NEG_CLAMP))
                                            : ENDP_W'($signed(b1));
      end else begin
         ends_in.e0 = $signed(ENDP_W'(b0));
         ends_in.e1 = $signed(ENDP_W'(b1));
      end
      ends_in.eight = ends_in.e0 > ends_in.e1;
      if (req_channel) begin
         front_bad_in   = bad_raw || pair_failed_ff;
         pair_failed_in = 1'b0;
      end else begin
         front_bad_in   = bad_raw;
         pair_failed_in = bad_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         signed_mode_ff <= 1'b0;
         pair_failed_ff <= 1'b0;
         front_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            signed_mode_ff <= csr_write_data;
         end
         if (req_accept) begin
            pair_failed_ff <= pair_failed_in;
            front_valid_ff <= 1'b1;
            front_ends_ff  <= ends_in;
            front_codes_ff <= req_block_bits[BLOCK_W-1:2*BYTE_W];
            front_bad_ff   <= front_bad_in;
            front_comp_ff  <= req_channel;
         end else if (front_take) begin
            front_valid_ff <= 1'b0;
         end
      end
   end

   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      rgtc_lane #(
         .CODE(g)
      ) u_lane (
         .clock      (clock),
         .load       (front_take),
         .ends       (front_ends_ff),
         .palette_ff (palette[g])
      );
   end

   rgtc_merge u_merge (
      .clock              (clock),
      .reset              (reset),
      .load               (front_take),
      .codes              (front_codes_ff),
      .bad                (front_bad_ff),
      .comp               (front_comp_ff),
      .palette            (palette),
      .back_free          (back_free),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_texel_index    (rsp_texel_index),
      .rsp_unsigned_value (rsp_unsigned_value),
      .rsp_signed_value   (rsp_signed_value),
      .rsp_component      (rsp_component),
      .rsp_invalid        (rsp_invalid),
      .rsp_last           (rsp_last)
   );

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> front_valid_ff)
      else $error("input stalled with empty input stage");

   a_pair_clear: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_channel |=> !pair_failed_ff)
      else $error("pair flag survived second component");

   a_take_loads: assert property (@(posedge clock) disable iff (reset)
      front_take && !req_accept |=> !front_valid_ff)
      else $error("input stage kept item after hand-off");

endmodule

>>> hw/rtl/rgtc_lane.sv
// One palette lane: computes and registers the palette entry for one texel code.
module rgtc_lane #(
   parameter int unsigned CODE = 0
) (
   input  logic                  clock,
   input  logic                  load,
   input  rgtc_pkg::ends_type    ends,
   output rgtc_pkg::lane_out_type palette_ff
);
   import rgtc_pkg::*;

   localparam int unsigned W7 = (CODE >= 1) ? CODE - 1 : 0;
   localparam int unsigned W5 = (CODE >= 2 && CODE <= 5) ? CODE - 1 : 0;
   localparam logic signed [4:0] A7 = 5'(7 - W7);
   localparam logic signed [4:0] B7 = 5'(W7);
   localparam logic signed [4:0] A5 = 5'(5 - W5);
   localparam logic signed [4:0] B5 = 5'(W5);
   localparam int unsigned NUM_W = 14;
   localparam int unsigned DIV_SHIFT = 14;
   localparam int unsigned DIV7_MUL = 2341;
   localparam int unsigned DIV5_MUL = 3277;

   function automatic logic signed [ENDP_W-1:0] div_tz(input logic signed [NUM_W-1:0] n,
                                                      input logic [12:0] mul);
      logic [NUM_W-2:0] mag;
      logic [25:0]      prod;
      logic [ENDP_W-1:0] q;
      mag  = n[NUM_W-1] ? (NUM_W-1)'(-n) : (NUM_W-1)'(n);
      prod = 26'(mag) * 26'(mul);
      q    = prod[DIV_SHIFT +: ENDP_W];
      return n[NUM_W-1] ? -$signed(q) : $signed(q);
   endfunction

   logic signed [NUM_W-1:0]  e0x;
   logic signed [NUM_W-1:0]  e1x;
   logic signed [NUM_W-1:0]  num7;
   logic signed [NUM_W-1:0]  num5;
   logic signed [ENDP_W-1:0] v;
   logic [UVAL_W-1:0]        ofs;
   logic [9:0]               tri_ofs;
   logic [1:0]               frac;
   logic [SVAL_W-1:0]        scaled;
   lane_out_type             palette_in;

   always_comb begin
      e0x  = NUM_W'(ends.e0);
      e1x  = NUM_W'(ends.e1);
      num7 = A7 * e0x + B7 * e1x;
      num5 = A5 * e0x + B5 * e1x;
      priority if (CODE == 0) begin
         v = ends.e0;
      end else if (CODE == 1) begin
         v = ends.e1;
      end else if (ends.eight) begin
         v = div_tz(num7, 13'(DIV7_MUL));
      end else if (CODE == 6) begin
         v = ends.sgn ? -10'sd127 : 10'sd0;
      end else if (CODE == 7) begin
         v = ends.sgn ? 10'sd127 : 10'sd255;
      end else begin
         v = div_tz(num5, 13'(DIV5_MUL));
      end

      // (v + 127) * 65535 / 254 = 258 * u + floor(3 * u / 254)
      ofs     = UVAL_W'(v + 10'sd127);
      tri_ofs = 10'(ofs) * 10'd3;
      frac    = 2'(tri_ofs >= 10'd254) + 2'(tri_ofs >= 10'd508) + 2'(tri_ofs >= 10'd762);
      scaled  = 16'(ofs) * 16'd258 + 16'(frac);

      palette_in.uval = ends.sgn ? '0 : v[UVAL_W-1:0];
      palette_in.sval = ends.sgn ? $signed({~scaled[SVAL_W-1], scaled[SVAL_W-2:0]}) : '0;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         palette_ff <= palette_in;
      end
   end

endmodule

>>> hw/rtl/rgtc_merge.sv
// Texel serializer: picks each texel's palette entry by code and drives the result channel.
module rgtc_merge (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              load,
   input  logic [rgtc_pkg::CODES_W-1:0]                      codes,
   input  logic                                              bad,
   input  logic                                              comp,
   input  rgtc_pkg::lane_out_type [rgtc_pkg::NUM_LANES-1:0]  palette,
   output logic                                              back_free,
   output logic                                              rsp_valid,
   input  logic                                              rsp_stall,
   output logic [rgtc_pkg::INDEX_W-1:0]                      rsp_texel_index,
   output logic [rgtc_pkg::UVAL_W-1:0]                       rsp_unsigned_value,
   output logic signed [rgtc_pkg::SVAL_W-1:0]                rsp_signed_value,
   output logic                                              rsp_component,
   output logic                                              rsp_invalid,
   output logic                                              rsp_last
);
   import rgtc_pkg::*;

   logic                  busy_ff;
   logic [INDEX_W-1:0]    count_ff;
   logic [CODES_W-1:0]    codes_ff;
   logic                  bad_ff;
   logic                  comp_ff;
   logic                  rsp_valid_ff;
   logic [INDEX_W-1:0]    index_ff;
   logic [UVAL_W-1:0]     uval_ff;
   logic signed [SVAL_W-1:0] sval_ff;
   logic                  comp_out_ff;
   logic                  bad_out_ff;
   logic                  last_ff;
   logic                  out_load;
   logic                  at_last;
   logic [CODE_W-1:0]     code;

   assign out_load  = busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign at_last   = count_ff == LAST_TEXEL;
   assign back_free = !busy_ff || (out_load && at_last);
   assign code      = codes_ff[CODE_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         if (load) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
            codes_ff <= codes;
            bad_ff   <= bad;
            comp_ff  <= comp;
         end else if (out_load) begin
            busy_ff  <= !at_last;
            count_ff <= count_ff + 1'b1;
            codes_ff <= codes_ff >> CODE_W;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
            index_ff     <= count_ff;
            uval_ff      <= bad_ff ? '0 : palette[code].uval;
            sval_ff      <= bad_ff ? '0 : palette[code].sval;
            comp_out_ff  <= comp_ff;
            bad_out_ff   <= bad_ff;
            last_ff      <= at_last;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_texel_index    = index_ff;
   assign rsp_unsigned_value = uval_ff;
   assign rsp_signed_value   = sval_ff;
   assign rsp_component      = comp_out_ff;
   assign rsp_invalid        = bad_out_ff;
   assign rsp_last           = last_ff;

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_invalid |-> rsp_unsigned_value == '0 && rsp_signed_value == '0)
      else $error("invalid item carries nonzero value");

   a_one_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_unsigned_value == '0 || rsp_signed_value == '0)
      else $error("both unsigned and signed values nonzero");

   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid)
      else $error("gap inside a block");

   a_free_when_idle: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> back_free && !out_load)
      else $error("serializer idle but not free");

endmodule
